// ===== sv/isort_pkg.sv =====
// types and constants shared by the insertion sorter modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      overflow;
  } out_item_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } isort_state_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } isort_cmd_t;

  typedef struct packed {
    logic last_one;
  } isort_status_t;

endpackage

`default_nettype wire

// ===== sv/insertion_sorter_core.sv =====
// insertion sorter top level: the first result follows in the cycle after the
// transfer marked last; a set of n stored values then drains without gaps
// values are accepted one per cycle while collecting; busy is high during the drain
// throughput is set by the shift-insertion chain, one value placed per cycle while collecting
// synchronous active-low reset empties the store and clears the overflow flag
// depends on isort_pkg, isort_ctrl, isort_dp
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter_core #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire isort_pkg::in_item_t  in_data,
  output      logic                 out_valid,
  output      isort_pkg::out_item_t out_data
);
  import isort_pkg::*;

  isort_cmd_t    cmd;
  isort_status_t status;
  logic          accept;

  assign accept = start && !busy;

  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .in_last   (in_data.last),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  isort_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last |=> out_valid)
    else $error("set end did not start the result stream");

  a_final_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_res |=> !busy && !out_valid)
    else $error("result stream did not end after final result");

  a_drain_continuous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_res |=> out_valid)
    else $error("gap in result stream");

endmodule

`default_nettype wire

// ===== sv/isort_ctrl.sv =====
// controller for the insertion sorter: collect and drain phases
// depends on isort_pkg
`timescale 1ns / 1ps
`default_nettype none

module isort_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   in_last,
  input  wire isort_pkg::isort_status_t status,
  output      isort_pkg::isort_cmd_t   cmd,
  output      logic                   busy,
  output      logic                   out_valid
);
  import isort_pkg::*;

  isort_state_t state_r;
  isort_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (start && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.last_one) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        cmd.insert = start;
      end
      ST_DRAIN: begin
        cmd.shift_out = 1'b1;
        busy          = 1'b1;
        out_valid     = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/isort_dp.sv =====
// datapath for the insertion sorter: shift-insertion chain, count and overflow flag
// depends on isort_pkg
`timescale 1ns / 1ps
`default_nettype none

module isort_dp #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire isort_pkg::in_item_t      in_data,
  input  wire isort_pkg::isort_cmd_t    cmd,
  output      isort_pkg::isort_status_t status,
  output      isort_pkg::out_item_t     out_data
);
  import isort_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  logic signed [VALUE_W-1:0] cells_r   [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] cells_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic [MAX_ENTRIES-1:0]    gt;
  logic                      full;

  assign full = (count_r == CNT_MAX);

  // cells holding a value greater than the arriving one
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (cells_r[i] > in_data.value);
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    if (cmd.insert) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (gt[i] || (CNT_W'(i) == count_r)) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
              cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
            end else begin
              cells_nxt[i] = in_data.value;
            end
          end
        end
      end
    end else if (cmd.shift_out) begin
      count_nxt = count_r - 1'b1;
      if (count_r == CNT_W'(1)) begin
        ovf_nxt = 1'b0;
      end
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        cells_nxt[i] = cells_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign status.last_one    = (count_r == CNT_W'(1));
  assign out_data.value_res = cells_r[0];
  assign out_data.last_res  = (count_r == CNT_W'(1));
  assign out_data.overflow  = ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("element count above store depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && full |=> ovf_r && count_r == CNT_MAX)
    else $error("drop at full store not flagged");

endmodule

`default_nettype wire

// ===== bench/insertion_sorter_core_tb.sv =====
// self-checking testbench for insertion_sorter_core: sends sets of signed values and
// checks each sorted output transfer against a behavioral sorter kept in the bench
// depends on isort_pkg and insertion_sorter_core
`timescale 1ns / 1ps

module insertion_sorter_core_tb;

  import isort_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = DEPTH + 8;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  insertion_sorter_core #(
    .MAX_ENTRIES(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the sorter state
  logic signed [VALUE_W-1:0] shadow_store[$];
  logic                      shadow_overflow = 1'b0;
  out_item_t                 sorted_expect_q[$];

  int unsigned idle_pct = 0;
  int unsigned items_accepted = 0;
  int unsigned sets_done = 0;
  int unsigned overflow_sets = 0;
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  task automatic insert_sorted(input logic signed [VALUE_W-1:0] v, input logic lst);
    int        pos;
    out_item_t res;
    pos = shadow_store.size();
    if (shadow_store.size() >= DEPTH) begin
      shadow_overflow = 1'b1;
    end else begin
      while (pos > 0 && shadow_store[pos-1] > v) pos--;
      shadow_store.insert(pos, v);
    end
    if (lst) begin
      for (int k = 0; k < shadow_store.size(); k++) begin
        res.value_res = shadow_store[k];
        res.last_res  = (k == shadow_store.size() - 1);
        res.overflow  = shadow_overflow;
        sorted_expect_q.push_back(res);
      end
      sets_done++;
      if (shadow_overflow) overflow_sets++;
      shadow_store.delete();
      shadow_overflow = 1'b0;
    end
  endtask

  // input transfer monitor
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      items_accepted++;
      insert_sorted(in_data.value, in_data.last);
    end
  end

  // output transfer checker
  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid) begin
      if (sorted_expect_q.size() == 0) begin
        note_error($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                             out_data.value_res, out_data.last_res, out_data.overflow));
      end else begin
        exp = sorted_expect_q.pop_front();
        results_checked++;
        if (out_data.value_res !== exp.value_res)
          note_error($sformatf("value_res expected %0d got %0d",
                               exp.value_res, out_data.value_res));
        if (out_data.last_res !== exp.last_res)
          note_error($sformatf("last_res expected %0b got %0b (value %0d)",
                               exp.last_res, out_data.last_res, exp.value_res));
        if (out_data.overflow !== exp.overflow)
          note_error($sformatf("overflow expected %0b got %0b (value %0d)",
                               exp.overflow, out_data.overflow, exp.value_res));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_data.value <= v;
    in_data.last  <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned mode;
    mode = $urandom_range(9);
    case (mode)
      0: begin
        return ($urandom_range(1) == 0) ? VAL_MIN : VAL_MAX;
      end
      1, 2, 3: begin
        return int'($urandom_range(16)) - 8;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  task automatic test_directed();
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shAAAA_AAAA, 1'b1);
    // equal values keep arrival order
    send_item(7, 1'b0);
    send_item(7, 1'b0);
    send_item(-7, 1'b0);
    send_item(7, 1'b1);
    for (int i = 5; i >= 1; i--) send_item(i, i == 1);
    for (int i = -3; i <= -1; i++) send_item(i, i == -1);
  endtask

  task automatic test_store_full();
    // last item fills the store exactly
    send_set(DEPTH);
    // last item arrives at a full store and is dropped
    send_set(DEPTH + 1);
    // several dropped items before the end of the set
    send_set(DEPTH + 4);
  endtask

  task automatic test_random_sets(input int unsigned pct, input int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    int unsigned n;
    idle_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70) n = $urandom_range(1, 6);
      else if (r < 92) n = $urandom_range(7, DEPTH);
      else n = $urandom_range(DEPTH + 1, DEPTH + 6);
      send_set(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 28;
    test_directed();
    test_store_full();
    test_random_sets(28, 60);
    test_random_sets(58, 60);
    test_random_sets(0, 60);
    start <= 1'b0;

    while (sorted_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sorted_expect_q.size() != 0)
      note_error($sformatf("%0d results never arrived", sorted_expect_q.size()));

    $display("covered %0d input transfers in %0d sets (%0d with dropped items)",
             items_accepted, sets_done, overflow_sets);
    $display("checked %0d sorted results, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
